/* rtl/core/eksi_pkg.sv */
// eksi_pkg: shared types and constants of the eased keyframe spline interpolator
// no dependencies; used by every module in rtl/core
package eksi_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int SINE_DEPTH_DEF = 256;

    localparam int POINT_W = 32;
    localparam int COEF_W  = 36;
    localparam int DIFF_W  = 33;

    // interpolation mode codes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_SPLINE = 2'd1;

    typedef enum logic [2:0] {
        EASE_LINEAR     = 3'd0,
        EASE_SQUARE     = 3'd1,
        EASE_OUT_SQUARE = 3'd2,
        EASE_OUT_SIXTH  = 3'd3,
        EASE_SINE2      = 3'd4
    } t_ease;

    // per-channel data carried alongside the time path
    typedef struct packed {
        logic signed [POINT_W-1:0] p1;
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [DIFF_W-1:0]  c;
        logic signed [DIFF_W-1:0]  dlt;
        logic [2:0]                kind;
        logic                      upd;
        logic                      spline;
        logic                      zero;
    } t_chan;

endpackage

/* rtl/core/eksi_div.sv */
// eksi_div: pipelined restoring divider, t = min(one, elapsed * 2^F / duration)
// depends on eksi_pkg
module eksi_div #(
    parameter int FRAC_BITS = eksi_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_elapsed,
    input  logic [31:0]          i_dur,
    input  eksi_pkg::t_chan      i_chan,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_t,
    output eksi_pkg::t_chan      o_chan
);
    import eksi_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic                 r_v   [0:FRAC_BITS];
    logic [31:0]          r_rem [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_q   [0:FRAC_BITS];
    logic                 r_sat [0:FRAC_BITS];
    logic [31:0]          r_d   [0:FRAC_BITS];
    t_chan                r_ch  [0:FRAC_BITS];

    // elapsed >= duration (zero duration included) saturates t to one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= i_elapsed;
        r_q[0]   <= '0;
        r_sat[0] <= (i_elapsed >= i_dur);
        r_d[0]   <= i_dur;
        r_ch[0]  <= i_chan;
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [32:0] n_shift;
        logic        n_ge;
        logic [32:0] n_rem;

        always_comb begin
            n_shift = {r_rem[k-1], 1'b0};
            n_ge    = (n_shift >= {1'b0, r_d[k-1]});
            n_rem   = n_ge ? (n_shift - {1'b0, r_d[k-1]}) : n_shift;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_rem[k] <= n_rem[31:0];
            r_q[k]   <= {r_q[k-1][FRAC_BITS-2:0], n_ge};
            r_sat[k] <= r_sat[k-1];
            r_d[k]   <= r_d[k-1];
            r_ch[k]  <= r_ch[k-1];
        end
    end

    assign o_valid = r_v[FRAC_BITS];
    assign o_t     = r_sat[FRAC_BITS] ? ONE : {1'b0, r_q[FRAC_BITS]};
    assign o_chan  = r_ch[FRAC_BITS];

endmodule

/* rtl/core/eksi_ease.sv */
// eksi_ease: easing curves on t, with the sine squared rom built at elaboration
// depends on eksi_pkg
module eksi_ease #(
    parameter int FRAC_BITS        = eksi_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = eksi_pkg::SINE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [FRAC_BITS:0]   i_t,
    input  eksi_pkg::t_chan      i_chan,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_e,
    output eksi_pkg::t_chan      o_chan
);
    import eksi_pkg::*;

    localparam int TW = FRAC_BITS + 1;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = FRAC_BITS + IW;
    localparam int SW = TW + 1 + FRAC_BITS + 1;

    localparam logic [TW-1:0]        ONE   = TW'(1) << FRAC_BITS;
    localparam logic [2*TW-1:0]      HALF2 = (2*TW)'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SHALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic [IW-1:0]        DEPTH = IW'(SINE_TABLE_DEPTH);
    localparam logic [63:0]          PI_Q30 = 64'd3373259426;

    typedef logic [TW-1:0] t_rom [0:SINE_TABLE_DEPTH];
    typedef logic [63:0] t_divs [0:11];
    localparam t_divs Divs = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                               64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    // q30 taylor sine, squared and rounded to q.F, capped at one
    function automatic t_rom build_rom();
        t_rom               rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        logic [63:0]        ev;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (PI_Q30 * 64'(i)) / (2 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 12; k++) begin
                term = ((term * x2) >> 30) / Divs[k-1];
                if (k % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            s = unsigned'(sum);
            if (s > (64'd1 << 30)) begin
                s = 64'd1 << 30;
            end
            ev = (s * s + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            if (ev > 64'(ONE)) begin
                ev = 64'(ONE);
            end
            rom[i] = TW'(ev);
        end
        return rom;
    endfunction

    localparam t_rom SIN2 = build_rom();

    // stage 1: products
    logic              r1_v;
    t_chan             r1_ch;
    logic [TW-1:0]     r1_t;
    logic [2*TW-1:0]   r1_tt, r1_uu;
    logic [PW-1:0]     r1_pos;
    logic [TW-1:0]     n1_u;

    assign n1_u = ONE - i_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_ch  <= i_chan;
        r1_t   <= i_t;
        r1_tt  <= (2*TW)'(i_t) * (2*TW)'(i_t);
        r1_uu  <= (2*TW)'(n1_u) * (2*TW)'(n1_u);
        r1_pos <= PW'(i_t) * PW'(DEPTH);
    end

    // stage 2: rounding, rom reads
    logic              r2_v;
    t_chan             r2_ch;
    logic [TW-1:0]     r2_t, r2_sq, r2_u2, r2_e0, r2_e1;
    logic [FRAC_BITS-1:0] r2_frac;
    logic              r2_top;
    logic [IW-1:0]     n2_idx, n2_idx0, n2_idx1;
    logic              n2_top;

    always_comb begin
        n2_idx  = r1_pos[PW-1:FRAC_BITS];
        n2_top  = (n2_idx >= DEPTH);
        n2_idx0 = n2_top ? (DEPTH - IW'(1)) : n2_idx;
        n2_idx1 = n2_idx0 + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_ch   <= r1_ch;
        r2_t    <= r1_t;
        r2_sq   <= TW'((r1_tt + HALF2) >> FRAC_BITS);
        r2_u2   <= TW'((r1_uu + HALF2) >> FRAC_BITS);
        r2_e0   <= SIN2[n2_idx0];
        r2_e1   <= SIN2[n2_idx1];
        r2_frac <= r1_pos[FRAC_BITS-1:0];
        r2_top  <= n2_top;
    end

    // stage 3: u^4 and sine interpolation products
    logic              r3_v;
    t_chan             r3_ch;
    logic [TW-1:0]     r3_t, r3_sq, r3_u2, r3_e0, r3_e1;
    logic              r3_top;
    logic [2*TW-1:0]   r3_u4p;
    logic signed [SW-1:0] r3_sinp;
    logic signed [TW:0]   n3_sd;

    assign n3_sd = $signed({1'b0, r2_e1}) - $signed({1'b0, r2_e0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_ch   <= r2_ch;
        r3_t    <= r2_t;
        r3_sq   <= r2_sq;
        r3_u2   <= r2_u2;
        r3_e0   <= r2_e0;
        r3_e1   <= r2_e1;
        r3_top  <= r2_top;
        r3_u4p  <= (2*TW)'(r2_u2) * (2*TW)'(r2_u2);
        r3_sinp <= SW'(n3_sd * $signed({1'b0, r2_frac}));
    end

    // stage 4: round u^4, finish sine
    logic              r4_v;
    t_chan             r4_ch;
    logic [TW-1:0]     r4_t, r4_sq, r4_u2, r4_u4, r4_sine;
    logic signed [SW-1:0] n4_adj;

    assign n4_adj = (r3_sinp + SHALF) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_ch   <= r3_ch;
        r4_t    <= r3_t;
        r4_sq   <= r3_sq;
        r4_u2   <= r3_u2;
        r4_u4   <= TW'((r3_u4p + HALF2) >> FRAC_BITS);
        r4_sine <= r3_top ? r3_e1 : TW'(SW'({1'b0, r3_e0}) + n4_adj);
    end

    // stage 5: u^6 product
    logic              r5_v;
    t_chan             r5_ch;
    logic [TW-1:0]     r5_t, r5_sq, r5_u2, r5_sine;
    logic [2*TW-1:0]   r5_u6p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_ch   <= r4_ch;
        r5_t    <= r4_t;
        r5_sq   <= r4_sq;
        r5_u2   <= r4_u2;
        r5_sine <= r4_sine;
        r5_u6p  <= (2*TW)'(r4_u4) * (2*TW)'(r4_u2);
    end

    // stage 6: curve select
    logic              r6_v;
    t_chan             r6_ch;
    logic [TW-1:0]     r6_e;
    logic [TW-1:0]     n6_e;

    always_comb begin
        unique case (t_ease'(r5_ch.kind))
            EASE_SQUARE:     n6_e = r5_sq;
            EASE_OUT_SQUARE: n6_e = ONE - r5_u2;
            EASE_OUT_SIXTH:  n6_e = ONE - TW'((r5_u6p + HALF2) >> FRAC_BITS);
            EASE_SINE2:      n6_e = r5_sine;
            default:         n6_e = r5_t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_ch <= r5_ch;
        r6_e  <= n6_e;
    end

    assign o_valid = r6_v;
    assign o_e     = r6_e;
    assign o_chan  = r6_ch;

endmodule

/* rtl/core/eksi_curve.sv */
// eksi_curve: lerp and horner catmull-rom evaluation at eased time, saturated
// depends on eksi_pkg
module eksi_curve #(
    parameter int FRAC_BITS = eksi_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [FRAC_BITS:0]   i_e,
    input  eksi_pkg::t_chan      i_chan,
    output logic                 o_valid,
    output logic signed [31:0]   o_value,
    output logic                 o_upd,
    output logic                 o_zero
);
    import eksi_pkg::*;

    localparam int EW = FRAC_BITS + 2;
    localparam int MA = COEF_W + EW;
    localparam int ML = DIFF_W + EW;
    localparam int HW = 40;
    localparam int MH = HW + EW;
    localparam int LW = 35;

    localparam logic signed [MA-1:0] HALF_A = MA'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ML-1:0] HALF_L = ML'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [MH-1:0] HALF_H = MH'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [HW-1:0] VMAX = HW'(32'sh7fffffff);
    localparam logic signed [HW-1:0] VMIN = HW'(signed'(32'h80000000));

    logic signed [EW-1:0] n_es;
    assign n_es = $signed({1'b0, i_e});

    // stage 1
    logic                 r1_v;
    t_chan                r1_ch;
    logic signed [EW-1:0] r1_e;
    logic signed [MA-1:0] r1_ma;
    logic signed [ML-1:0] r1_ml;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_ch <= i_chan;
        r1_e  <= n_es;
        r1_ma <= MA'(i_chan.a * n_es);
        r1_ml <= ML'(i_chan.dlt * n_es);
    end

    // stage 2
    logic                 r2_v;
    t_chan                r2_ch;
    logic signed [EW-1:0] r2_e;
    logic signed [HW-1:0] r2_h;
    logic signed [LW-1:0] r2_lin;
    logic signed [MA-1:0] n2_ra;
    logic signed [ML-1:0] n2_rl;

    assign n2_ra = (r1_ma + HALF_A) >>> FRAC_BITS;
    assign n2_rl = (r1_ml + HALF_L) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_ch  <= r1_ch;
        r2_e   <= r1_e;
        r2_h   <= HW'(n2_ra) + HW'(r1_ch.b);
        r2_lin <= LW'(n2_rl) + LW'(r1_ch.p1);
    end

    // stage 3
    logic                 r3_v;
    t_chan                r3_ch;
    logic signed [EW-1:0] r3_e;
    logic signed [MH-1:0] r3_m;
    logic signed [LW-1:0] r3_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_ch  <= r2_ch;
        r3_e   <= r2_e;
        r3_lin <= r2_lin;
        r3_m   <= MH'(r2_h * r2_e);
    end

    // stage 4
    logic                 r4_v;
    t_chan                r4_ch;
    logic signed [EW-1:0] r4_e;
    logic signed [HW-1:0] r4_h;
    logic signed [LW-1:0] r4_lin;
    logic signed [MH-1:0] n4_r;

    assign n4_r = (r3_m + HALF_H) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_ch  <= r3_ch;
        r4_e   <= r3_e;
        r4_lin <= r3_lin;
        r4_h   <= HW'(n4_r) + HW'(r3_ch.c);
    end

    // stage 5
    logic                 r5_v;
    t_chan                r5_ch;
    logic signed [MH-1:0] r5_m;
    logic signed [LW-1:0] r5_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_ch  <= r4_ch;
        r5_lin <= r4_lin;
        r5_m   <= MH'(r4_h * r4_e);
    end

    // stage 6
    logic                 r6_v;
    t_chan                r6_ch;
    logic signed [HW-1:0] r6_h;
    logic signed [LW-1:0] r6_lin;
    logic signed [MH-1:0] n6_r;

    assign n6_r = (r5_m + HALF_H) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_ch  <= r5_ch;
        r6_lin <= r5_lin;
        r6_h   <= HW'(n6_r) + (HW'(r5_ch.p1) <<< 1);
    end

    // stage 7: halve, select, saturate
    logic                 r7_v;
    logic signed [31:0]   r7_value;
    logic                 r7_upd;
    logic                 r7_zero;
    logic signed [HW-1:0] n7_v;
    logic signed [31:0]   n7_sat;

    always_comb begin
        if (!r6_ch.upd) begin
            n7_v = '0;
        end else if (r6_ch.spline) begin
            n7_v = (r6_h + HW'(1)) >>> 1;
        end else begin
            n7_v = HW'(r6_lin);
        end
        priority if (n7_v > VMAX) begin
            n7_sat = 32'sh7fffffff;
        end else if (n7_v < VMIN) begin
            n7_sat = signed'(32'h80000000);
        end else begin
            n7_sat = n7_v[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_value <= n7_sat;
        r7_upd   <= r6_ch.upd;
        r7_zero  <= r6_ch.zero;
    end

    assign o_valid = r7_v;
    assign o_value = r7_value;
    assign o_upd   = r7_upd;
    assign o_zero  = r7_zero;

endmodule

/* rtl/core/eased_keyframe_spline_interp_top.sv */
// eased_keyframe_spline_interp_top: top level of the eased keyframe interpolator
// depends on eksi_pkg, eksi_div, eksi_ease, eksi_curve
//
// one request per clock: busy is never raised, so start alone launches a channel.
// every request gives exactly one result, marked by o_valid for one cycle;
// the receiver cannot stall, so results must be taken as they come. the path
// runs through one input stage, the time divider (FRAC_BITS + 1 stages: a load
// stage, then one quotient bit per stage), six easing stages (the sixth-power
// curve chains three rounded multiplies) and seven curve stages (three horner
// multiplies, each rounded in its own stage).
// the sine squared table has SINE_TABLE_DEPTH + 1 entries fixed at elaboration.
module eased_keyframe_spline_interp_top #(
    parameter int FRAC_BITS        = eksi_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = eksi_pkg::SINE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_point_before_prev,
    input  logic signed [31:0] i_point_prev,
    input  logic signed [31:0] i_point_current,
    input  logic signed [31:0] i_point_next,
    input  logic [31:0]        i_frame_elapsed,
    input  logic [31:0]        i_frame_duration,
    input  logic [1:0]         i_interp_mode,
    input  logic [2:0]         i_ease_kind,
    input  logic               i_prev_present,
    input  logic               i_before_prev_present,
    input  logic               i_next_present,
    input  logic               i_is_scale_channel,
    output logic               o_valid,
    output logic signed [31:0] o_interp_value,
    output logic               o_value_updated,
    output logic               o_zero_duration
);
    import eksi_pkg::*;

    localparam int LATENCY = FRAC_BITS + 15;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    // fully pipelined, never refuses a request
    assign busy = 1'b0;

    logic n_accept;
    assign n_accept = start && !busy;

    // missing frame substitution and curve coefficients
    logic signed [31:0]     n_p0, n_p1, n_p2, n_p3;
    logic signed [COEF_W-1:0] n_x0, n_x1, n_x2, n_x3;
    t_chan                  n_ch;

    always_comb begin
        n_p2 = i_point_current;
        if (i_prev_present) begin
            n_p1 = i_point_prev;
        end else begin
            n_p1 = i_is_scale_channel ? ONE : 32'sd0;
        end
        n_p0 = i_before_prev_present ? i_point_before_prev : n_p1;
        n_p3 = i_next_present ? i_point_next : n_p2;
        n_x0 = COEF_W'(n_p0);
        n_x1 = COEF_W'(n_p1);
        n_x2 = COEF_W'(n_p2);
        n_x3 = COEF_W'(n_p3);

        n_ch.p1     = n_p1;
        n_ch.a      = n_x3 - n_x0 + (n_x1 <<< 1) + n_x1 - (n_x2 <<< 1) - n_x2;
        n_ch.b      = (n_x0 <<< 1) - (n_x1 <<< 2) - n_x1 + (n_x2 <<< 2) - n_x3;
        n_ch.c      = DIFF_W'(n_p2) - DIFF_W'(n_p0);
        n_ch.dlt    = DIFF_W'(n_p2) - DIFF_W'(n_p1);
        n_ch.kind   = i_ease_kind;
        n_ch.upd    = (i_interp_mode == MODE_LINEAR) || (i_interp_mode == MODE_SPLINE);
        n_ch.spline = (i_interp_mode == MODE_SPLINE);
        n_ch.zero   = (i_frame_duration == 32'd0);
    end

    // input stage
    logic        r_v;
    t_chan       r_ch;
    logic [31:0] r_elapsed;
    logic [31:0] r_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_accept;
        end
        r_ch      <= n_ch;
        r_elapsed <= i_frame_elapsed;
        r_dur     <= i_frame_duration;
    end

    // normalized time
    logic               w_t_valid;
    logic [FRAC_BITS:0] w_t;
    t_chan              w_t_ch;

    eksi_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v),
        .i_elapsed (r_elapsed),
        .i_dur     (r_dur),
        .i_chan    (r_ch),
        .o_valid   (w_t_valid),
        .o_t       (w_t),
        .o_chan    (w_t_ch)
    );

    // eased time
    logic               w_e_valid;
    logic [FRAC_BITS:0] w_e;
    t_chan              w_e_ch;

    eksi_ease #(
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_t_valid),
        .i_t     (w_t),
        .i_chan  (w_t_ch),
        .o_valid (w_e_valid),
        .o_e     (w_e),
        .o_chan  (w_e_ch)
    );

    // curve evaluation and output register
    eksi_curve #(
        .FRAC_BITS(FRAC_BITS)
    ) u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_e_valid),
        .i_e     (w_e),
        .i_chan  (w_e_ch),
        .o_valid (o_valid),
        .o_value (o_interp_value),
        .o_upd   (o_value_updated),
        .o_zero  (o_zero_duration)
    );

    // every request yields a result after the fixed latency
    a_latency_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> ##(LATENCY) o_valid)
        else $error("result missing after request");

    // no result appears without a request
    a_latency_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_accept |-> ##(LATENCY) !o_valid)
        else $error("result without request");

    // modes none and spare (no update) produce a zero value
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_value_updated) |-> (o_interp_value == 32'sd0))
        else $error("non-zero value with no update");

endmodule

/* verif/eased_keyframe_spline_interp_top_test.sv */
// testbench for eased_keyframe_spline_interp_top: random and directed channel requests
// checked against an in-bench fixed-point predictor; depends on eksi_pkg and the rtl top
module eased_keyframe_spline_interp_top_test;
    import eksi_pkg::*;

    localparam int F     = FRAC_BITS_DEF;
    localparam int DEPTH = SINE_DEPTH_DEF;
    localparam longint ONE = 64'd1 << F;
    localparam longint HALF = 64'd1 << (F - 1);
    localparam int LIMIT = 400000;
    localparam logic [1:0] MODE_NONE = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // one channel request as driven on the ports
    typedef struct {
        logic [31:0] pbp, pp, pc, pn, elapsed, duration;
        logic [1:0]  mode;
        logic [2:0]  kind;
        logic        prev_ok, bprev_ok, next_ok, scale;
    } t_req;

    typedef struct {
        logic [31:0] value;
        logic        upd, zero;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [31:0] i_point_before_prev = '0, i_point_prev = '0;
    logic signed [31:0] i_point_current = '0, i_point_next = '0;
    logic [31:0] i_frame_elapsed = '0, i_frame_duration = '0;
    logic [1:0]  i_interp_mode = '0;
    logic [2:0]  i_ease_kind = '0;
    logic        i_prev_present = 1'b0, i_before_prev_present = 1'b0;
    logic        i_next_present = 1'b0, i_is_scale_channel = 1'b0;
    logic        o_valid;
    logic signed [31:0] o_interp_value;
    logic        o_value_updated, o_zero_duration;

    eased_keyframe_spline_interp_top u_top (.*);

    always #5 i_clk = ~i_clk;

    t_req   pending_reqs[$];
    t_res   expected_results[$];
    longint sin2_table[DEPTH+1];
    int     idle_phases[4] = '{0, 80, 0, 34};
    int     idle_pct = 0;     // sender idle chance in percent
    bit     hold_off = 1'b0;  // sender pauses until the pipe drains
    bit     stim_done = 1'b0;
    int     errors = 0;
    int     cycles = 0;

    // sine squared table: q30 taylor sine, squared and rounded to q.F
    function automatic void build_sin2();
        longint unsigned x, x2, term, s, e;
        longint sum;
        for (int i = 0; i <= DEPTH; i++) begin
            x = (64'd3373259426 * i) / (2 * DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k & 1) sum -= term;
                else sum += term;
            end
            if (sum < 0) sum = 0;
            s = sum;
            if (s > (64'd1 << 30)) s = 64'd1 << 30;
            e = (s * s + (64'd1 << (59 - F))) >> (60 - F);
            if (e > ONE) e = ONE;
            sin2_table[i] = e;
        end
    endfunction

    // signed round to nearest, ties toward +inf (arithmetic shift floors)
    function automatic longint rnd_q(longint v);
        return (v + HALF) >>> F;
    endfunction

    function automatic longint eased_time(longint t, logic [2:0] kind);
        longint u, u2, u4, pos, idx, fr;
        u = ONE - t;
        case (kind)
            EASE_SQUARE:     return (t * t + HALF) >> F;
            EASE_OUT_SQUARE: return ONE - ((u * u + HALF) >> F);
            EASE_OUT_SIXTH: begin
                u2 = (u * u + HALF) >> F;
                u4 = (u2 * u2 + HALF) >> F;
                return ONE - ((u4 * u2 + HALF) >> F);
            end
            EASE_SINE2: begin
                pos = t * DEPTH;
                idx = pos >> F;
                fr = pos & (ONE - 1);
                if (idx >= DEPTH) return sin2_table[DEPTH];
                return sin2_table[idx] + rnd_q((sin2_table[idx+1] - sin2_table[idx]) * fr);
            end
            default:         return t;
        endcase
    endfunction

    function automatic t_res channel_value(t_req r);
        t_res   res;
        longint t, e, p0, p1, p2, p3, a, b, c, h, v;
        res.zero = (r.duration == 0);
        if (res.zero) t = ONE;
        else begin
            t = ({32'd0, r.elapsed} << F) / r.duration;
            if (t > ONE) t = ONE;
        end
        e = eased_time(t, r.kind);
        p2 = $signed(r.pc);
        p1 = r.prev_ok ? longint'($signed(r.pp)) : (r.scale ? ONE : 0);
        p0 = r.bprev_ok ? longint'($signed(r.pbp)) : p1;
        p3 = r.next_ok ? longint'($signed(r.pn)) : p2;
        v = 0;
        if (r.mode == MODE_LINEAR) v = p1 + rnd_q((p2 - p1) * e);
        else if (r.mode == MODE_SPLINE) begin
            a = -p0 + 3 * p1 - 3 * p2 + p3;
            b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c = p2 - p0;
            h = rnd_q(a * e) + b;
            h = rnd_q(h * e) + c;
            h = rnd_q(h * e) + 2 * p1;
            v = (h + 1) >>> 1;
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        res.value = v[31:0];
        res.upd = (r.mode == MODE_LINEAR) || (r.mode == MODE_SPLINE);
        return res;
    endfunction

    // 32-bit values biased toward extremes and small numbers
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) << 16;
            3: return -($urandom_range(0, 4) << 16);
            4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_req();
        t_req r;
        r.pbp = pick_word(); r.pp = pick_word();
        r.pc = pick_word();  r.pn = pick_word();
        case ($urandom_range(0, 5))
            0: r.duration = 0;
            1: r.duration = $urandom;
            2: r.duration = 32'hffffffff;
            default: r.duration = $urandom_range(1, 32'h40000);
        endcase
        case ($urandom_range(0, 4))
            0: r.elapsed = $urandom;
            1: r.elapsed = r.duration;
            2: r.elapsed = 0;
            default: r.elapsed = (r.duration == 0) ? $urandom : $urandom_range(0, r.duration);
        endcase
        r.mode = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
        r.kind = 3'($urandom_range(0, 7));
        r.prev_ok = $urandom_range(0, 3) != 0;
        r.bprev_ok = $urandom_range(0, 3) != 0;
        r.next_ok = $urandom_range(0, 3) != 0;
        r.scale = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // driver: a request is taken on every edge with start high (busy never rises)
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(channel_value('{i_point_before_prev,
                i_point_prev, i_point_current, i_point_next, i_frame_elapsed,
                i_frame_duration, i_interp_mode, i_ease_kind, i_prev_present,
                i_before_prev_present, i_next_present, i_is_scale_channel}));
            void'(pending_reqs.pop_front());
        end
        if (i_rst_n && pending_reqs.size() > 0 && !hold_off
                && $urandom_range(0, 99) >= idle_pct) begin
            // head of the queue is the oldest request not yet taken
            r = pending_reqs[0];
            start <= 1'b1;
            i_point_before_prev <= r.pbp; i_point_prev <= r.pp;
            i_point_current <= r.pc;      i_point_next <= r.pn;
            i_frame_elapsed <= r.elapsed; i_frame_duration <= r.duration;
            i_interp_mode <= r.mode;      i_ease_kind <= r.kind;
            i_prev_present <= r.prev_ok;  i_before_prev_present <= r.bprev_ok;
            i_next_present <= r.next_ok;  i_is_scale_channel <= r.scale;
        end else if (start && !busy) begin
            start <= 1'b0;
        end
    end

    // monitor: every strobed result is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_res exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result value=%h", $time, o_interp_value);
                errors <= errors + 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_interp_value !== exp_r.value || o_value_updated !== exp_r.upd
                        || o_zero_duration !== exp_r.zero) begin
                    $display("%0t: mismatch exp value=%h upd=%b zero=%b act value=%h upd=%b zero=%b",
                        $time, exp_r.value, exp_r.upd, exp_r.zero,
                        o_interp_value, o_value_updated, o_zero_duration);
                    errors <= errors + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start) @(posedge i_clk);
    endtask

    initial begin
        t_req d;
        build_sin2();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each ease kind and mode, the field extremes and substitutions
        for (int k = 0; k < 8; k++) begin
            d = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h8000, 32'h10000, MODE_SPLINE, 3'(k), 1, 1, 1, 0};
            pending_reqs.push_back(d);
        end
        d = '{32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h5, 32'h0,
              MODE_LINEAR, EASE_LINEAR, 1, 1, 1, 0};
        pending_reqs.push_back(d);                           // zero duration
        d.duration = 32'hffffffff; d.elapsed = 32'hffffffff;
        pending_reqs.push_back(d);                           // full word times
        d.elapsed = 32'h30000; d.duration = 32'h10000;
        pending_reqs.push_back(d);                           // elapsed past end
        d.mode = MODE_NONE; pending_reqs.push_back(d);
        d.mode = MODE_SPARE; d.duration = 0; pending_reqs.push_back(d);
        d.mode = MODE_SPLINE; d.elapsed = 32'h4000; d.duration = 32'h10000;
        d.prev_ok = 0; d.scale = 1; pending_reqs.push_back(d); // scale default
        d.scale = 0; d.bprev_ok = 0; pending_reqs.push_back(d);
        d.next_ok = 0; d.prev_ok = 1; pending_reqs.push_back(d);
        d = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'hc000, 32'h10000, MODE_SPLINE, EASE_SINE2, 1, 1, 1, 1};
        pending_reqs.push_back(d);                           // overflow
        d.mode = MODE_LINEAR; pending_reqs.push_back(d);
        wait_drained();

        // random phases with different sender gaps
        foreach (idle_phases[p]) begin
            idle_pct = idle_phases[p];
            for (int n = 0; n < 335; n++) pending_reqs.push_back(random_req());
            wait_drained();
            if (p == 1) begin
                // let every result out before going on
                hold_off = 1'b1;
                while (expected_results.size() > 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end

        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (3 * F + 50) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
